// ----- hdl/lgr_pkg.sv -----
// Shared types, constants and the Life rule for the row-streaming Life generator.
// No dependencies; used by lgr_cell, lgr_out_queue and life_generation_rows.
package lgr_pkg;

  localparam int MAX_COLS    = 64;
  localparam int COL_W       = 7;    // active_cols register width
  localparam int CFG_ADDR_W  = 1;
  localparam int CFG_DATA_W  = 32;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Register addresses
  localparam logic [CFG_ADDR_W-1:0] ADDR_ACTIVE_COLS = 1'b0;
  localparam logic [COL_W-1:0]      ACTIVE_COLS_RST  = COL_W'(MAX_COLS);

  // Life rule constants
  localparam logic [3:0] BIRTH_CNT   = 4'd3;
  localparam logic [3:0] SURVIVE_CNT = 4'd2;

  // Masked bits a cell shows to its neighbours
  typedef struct packed {
    logic above;
    logic middle;
    logic incoming;
  } nbr_t;

  // One result item
  typedef struct packed {
    logic                last;
    logic [MAX_COLS-1:0] row;
  } out_item_t;

  // Number of live bits among eight neighbours
  function automatic logic [3:0] popcount8(input logic [7:0] bits);
    logic [3:0] sum;
    sum = 4'd0;
    for (int i = 0; i < 8; i++) begin
      sum = sum + {3'b000, bits[i]};
    end
    return sum;
  endfunction

  // B3/S23
  function automatic logic life_rule(input logic alive, input logic [3:0] cnt);
    return (cnt == BIRTH_CNT) || (alive && (cnt == SURVIVE_CNT));
  endfunction

endpackage

// ----- hdl/lgr_cell.sv -----
// One grid column: holds the above and middle bits and computes next states.
// Depends on lgr_pkg (nbr_t, popcount8, life_rule).
module lgr_cell (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         load,       // item accepted this cycle
  input  logic         clear,      // accepted item is the last row
  input  logic         in_bit,
  input  logic         col_en,     // column lies below active_cols
  input  lgr_pkg::nbr_t nbr_lo,    // column c-1
  input  lgr_pkg::nbr_t nbr_hi,    // column c+1
  output lgr_pkg::nbr_t own,
  output logic         res_mid,    // next state of the held middle row
  output logic         res_last    // next state of the incoming row, dead below
);
  import lgr_pkg::*;

  logic above_r, above_nxt;
  logic middle_r, middle_nxt;
  logic [3:0] cnt_mid;
  logic [3:0] cnt_last;

  // Masked view shared with neighbours
  assign own.above    = above_r & col_en;
  assign own.middle   = middle_r & col_en;
  assign own.incoming = in_bit & col_en;

  // Eight-neighbour counts for both candidate results
  assign cnt_mid  = popcount8({nbr_lo.above, own.above, nbr_hi.above,
                               nbr_lo.middle, nbr_hi.middle,
                               nbr_lo.incoming, own.incoming, nbr_hi.incoming});
  assign cnt_last = popcount8({nbr_lo.middle, own.middle, nbr_hi.middle,
                               nbr_lo.incoming, nbr_hi.incoming, 3'b000});

  assign res_mid  = life_rule(own.middle, cnt_mid) & col_en;
  assign res_last = life_rule(own.incoming, cnt_last) & col_en;

  // Shift rows down; the last row empties the window
  always_comb begin
    above_nxt  = above_r;
    middle_nxt = middle_r;
    if (load) begin
      if (clear) begin
        above_nxt  = 1'b0;
        middle_nxt = 1'b0;
      end else begin
        above_nxt  = middle_r;
        middle_nxt = in_bit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      above_r  <= 1'b0;
      middle_r <= 1'b0;
    end else begin
      above_r  <= above_nxt;
      middle_r <= middle_nxt;
    end
  end

endmodule

// ----- hdl/lgr_out_queue.sv -----
// Small result queue: takes up to two items a cycle, gives one a cycle while the head is taken.
// Depends on lgr_pkg (out_item_t, QUEUE_DEPTH, pointer widths).
module lgr_out_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [1:0]        push_n,    // items pushed this cycle, 0 to 2
  input  lgr_pkg::out_item_t push0,
  input  lgr_pkg::out_item_t push1,
  output logic              room,      // space for two more items
  output logic              head_valid,
  input  logic              head_taken,
  output lgr_pkg::out_item_t head
);
  import lgr_pkg::*;

  out_item_t entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic [QPTR_W-1:0] wr_ptr_p1;
  logic              pop;

  assign pop        = head_valid & head_taken;
  assign head_valid = (count_r != '0);
  assign head       = entry_r[rd_ptr_r];
  assign room       = (count_r <= QCNT_W'(QUEUE_DEPTH - 2));
  assign wr_ptr_p1  = wr_ptr_r + QPTR_W'(1);

  // Pointer and fill arithmetic
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + QPTR_W'(push_n);
    rd_ptr_nxt = rd_ptr_r + QPTR_W'(pop);
    count_nxt  = count_r + QCNT_W'(push_n) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage, no reset
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      entry_r[wr_ptr_r] <= push0;
    end
    if (push_n == 2'd2) begin
      entry_r[wr_ptr_p1] <= push1;
    end
  end

endmodule

// ----- hdl/life_generation_rows.sv -----
// Results are written into the output queue when the row that completes them is accepted.
// Throughput: one row per cycle while in_tready is high; a last row that follows a held row
// yields two items, which the output side takes one at a time, absorbed by a 4-item queue.
// The input stalls only when that queue holds more than two items.
// Reset (rst_n low, synchronous): window rows dead, queue empty, active_cols 64.
// Depends on lgr_pkg, lgr_cell and lgr_out_queue.
module life_generation_rows (
  input  logic                              clk,
  input  logic                              rst_n,
  // Row input
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [lgr_pkg::MAX_COLS-1:0]      in_tdata,   // [63:0] row_cells
  input  logic                              in_tlast,   // last_row
  // Result output
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [lgr_pkg::MAX_COLS-1:0]      out_tdata,  // [63:0] next_row
  output logic                              out_tlast,  // last_out
  // Configuration
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [lgr_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [lgr_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic [lgr_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                              cfg_pready
);
  import lgr_pkg::*;

  logic [COL_W-1:0] active_cols_r, active_cols_nxt;
  logic             have_middle_r, have_middle_nxt;
  logic             accept;
  logic             room;
  logic [MAX_COLS-1:0] col_en;
  logic [MAX_COLS-1:0] res_mid;
  logic [MAX_COLS-1:0] res_last;
  nbr_t             own [MAX_COLS];
  nbr_t             nbr_lo [MAX_COLS];
  nbr_t             nbr_hi [MAX_COLS];
  logic [1:0]       push_n;
  out_item_t        push0, push1, head;

  // Configuration register
  assign cfg_pready = 1'b1;
  always_comb begin
    active_cols_nxt = active_cols_r;
    if (cfg_psel && cfg_penable && cfg_pwrite && (cfg_paddr == ADDR_ACTIVE_COLS)) begin
      active_cols_nxt = cfg_pwdata[COL_W-1:0];
    end
  end
  assign cfg_prdata = (cfg_paddr == ADDR_ACTIVE_COLS)
                    ? {{(CFG_DATA_W-COL_W){1'b0}}, active_cols_r} : '0;

  // Window control
  assign in_tready = room;
  assign accept    = in_tvalid & room;

  always_comb begin
    have_middle_nxt = have_middle_r;
    if (accept) begin
      have_middle_nxt = ~in_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_cols_r <= ACTIVE_COLS_RST;
      have_middle_r <= 1'b0;
    end else begin
      active_cols_r <= active_cols_nxt;
      have_middle_r <= have_middle_nxt;
    end
  end

  // Row of cells, dead beyond both grid edges
  for (genvar c = 0; c < MAX_COLS; c++) begin : g_col
    assign col_en[c] = (COL_W'(c) < active_cols_r);
    if (c == 0) begin : g_lo_edge
      assign nbr_lo[c] = '0;
    end else begin : g_lo
      assign nbr_lo[c] = own[c-1];
    end
    if (c == MAX_COLS - 1) begin : g_hi_edge
      assign nbr_hi[c] = '0;
    end else begin : g_hi
      assign nbr_hi[c] = own[c+1];
    end
    lgr_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .load     (accept),
      .clear    (in_tlast),
      .in_bit   (in_tdata[c]),
      .col_en   (col_en[c]),
      .nbr_lo   (nbr_lo[c]),
      .nbr_hi   (nbr_hi[c]),
      .own      (own[c]),
      .res_mid  (res_mid[c]),
      .res_last (res_last[c])
    );
  end

  // Results of one item: held middle row first, then the last row
  always_comb begin
    push_n      = 2'd0;
    push0.row   = res_mid;
    push0.last  = 1'b0;
    push1.row   = res_last;
    push1.last  = 1'b1;
    if (accept) begin
      push_n = {1'b0, have_middle_r} + {1'b0, in_tlast};
      if (!have_middle_r) begin
        push0.row  = res_last;
        push0.last = 1'b1;
      end
    end
  end

  lgr_out_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_n     (push_n),
    .push0      (push0),
    .push1      (push1),
    .room       (room),
    .head_valid (out_tvalid),
    .head_taken (out_tready),
    .head       (head)
  );

  assign out_tdata = head.row;
  assign out_tlast = head.last;

endmodule
